// File: design/wtdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtdr_pkg
// Shared types and constants of the wireframe triangle DDA rasterizer.
// ----------------------------------------------------------------------------
package wtdr_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 2;
  localparam int QUOT_BITS  = FRAC_BITS + 1;
  localparam int INC_BITS   = FRAC_BITS + 2;
  localparam int REM_BITS   = DELTA_BITS + 1;
  localparam int CNT_BITS   = $clog2(QUOT_BITS);
  localparam int EDGE_BITS  = 2;
  localparam int COLOR_BITS = 32;

  localparam logic [COLOR_BITS-1:0] COLOR_RESET = 32'hFFFF_FF00;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [EDGE_BITS-1:0] EDGE_AB = 2'd0;
  localparam logic [EDGE_BITS-1:0] EDGE_BC = 2'd1;
  localparam logic [EDGE_BITS-1:0] EDGE_CA = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_X,
    ST_DIV_Y,
    ST_WALK
  } seq_state_e;

  typedef struct packed {
    logic                  start;
    logic [DELTA_BITS-1:0] num;
    logic [DELTA_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [QUOT_BITS-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                         valid;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [EDGE_BITS-1:0]         edge_id;
    logic                         last;
  } pix_t;

endpackage

// File: design/wireframe_triangle_dda_raster_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wireframe_triangle_dda_raster_core
// Wireframe triangle rasterizer built from three DDA edge walks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per command. tuser = kind: load (vertices in tdata)
//   or step (tdata ignored). A load gives no output; each step while a triangle
//   is in progress gives one pixel word on m_axis, with tlast on the final pixel
//   of edge c-a. A step while idle is taken and dropped.
//   Edge setup runs a serial divider twice (x then y increment), one quotient
//   bit a cycle: a load or the step that closes edge a-b or b-c keeps
//   s_axis_tready low until both divisions are done. Other steps need no setup,
//   and the pixel is valid on m_axis the cycle after the step is taken.
//   cfg carries the pixel color; write it only while idle. It is always ready.
//   m_axis has an output register; a stall holds the word and blocks further
//   steps until it is taken.
//   Reset: idle, no triangle, color 0xFFFFFF00, output empty.
// ----------------------------------------------------------------------------
module wireframe_triangle_dda_raster_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,     // pixel_color
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // ax, ay, bx, by_coord, cx, cy
  input  logic [0:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // pixel_x, pixel_y, pixel_rgba, edge_id, zero pad
  output logic        m_axis_tlast
);
  import wtdr_pkg::*;

  logic [COLOR_BITS-1:0]        color_q;
  logic                         out_vld_q;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [COLOR_BITS-1:0]        out_rgba_q;
  logic [EDGE_BITS-1:0]         out_edge_q;
  logic                         out_last_q;

  logic seq_ready, take;
  pix_t pix;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = seq_ready && (!out_vld_q || m_axis_tready);
  assign take          = s_axis_tvalid && s_axis_tready;

  wtdr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .kind_i     (s_axis_tuser[0]),
    .ax_i       (s_axis_tdata[11:0]),
    .ay_i       (s_axis_tdata[23:12]),
    .bx_i       (s_axis_tdata[35:24]),
    .by_coord_i (s_axis_tdata[47:36]),
    .cx_i       (s_axis_tdata[59:48]),
    .cy_i       (s_axis_tdata[71:60]),
    .ready_o    (seq_ready),
    .pix_o      (pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q   <= COLOR_RESET;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        color_q <= cfg_data_i;
      end
      if (pix.valid) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix.valid) begin
      out_x_q    <= pix.x;
      out_y_q    <= pix.y;
      out_rgba_q <= color_q;
      out_edge_q <= pix.edge_id;
      out_last_q <= pix.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_edge_q, out_rgba_q, out_y_q, out_x_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// File: design/wtdr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtdr_div
// Serial restoring divider: (num * 2^FRAC_BITS) / den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module wtdr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wtdr_pkg::div_req_t req_i,
  output wtdr_pkg::div_rsp_t rsp_o
);
  import wtdr_pkg::*;

  logic                  run_q, run_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [REM_BITS-1:0]   rem_q, rem_d;
  logic [QUOT_BITS-1:0]  quot_q, quot_d;
  logic [DELTA_BITS-1:0] den_q, den_d;

  logic                ge;
  logic [REM_BITS-1:0] diff;
  logic [REM_BITS-1:0] rem_nx;

  assign ge     = rem_q >= {1'b0, den_q};
  assign diff   = rem_q - {1'b0, den_q};
  assign rem_nx = ge ? diff : rem_q;

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    den_d  = den_q;
    if (req_i.start) begin
      run_d  = 1'b1;
      cnt_d  = CNT_BITS'(QUOT_BITS - 1);
      rem_d  = {1'b0, req_i.num};
      quot_d = '0;
      den_d  = req_i.den;
    end else if (run_q) begin
      quot_d = {quot_q[QUOT_BITS-2:0], ge};
      rem_d  = {rem_nx[REM_BITS-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = run_q && (cnt_q == '0);
  assign rsp_o.quot = {quot_q[QUOT_BITS-2:0], ge};

endmodule

// File: design/wtdr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtdr_seq
// Edge sequencer: vertex store, edge setup, increment division and DDA walk.
// ----------------------------------------------------------------------------
module wtdr_seq (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   take_i,
  input  logic                                   kind_i,
  input  logic signed [wtdr_pkg::COORD_BITS-1:0] ax_i,
  input  logic signed [wtdr_pkg::COORD_BITS-1:0] ay_i,
  input  logic signed [wtdr_pkg::COORD_BITS-1:0] bx_i,
  input  logic signed [wtdr_pkg::COORD_BITS-1:0] by_coord_i,
  input  logic signed [wtdr_pkg::COORD_BITS-1:0] cx_i,
  input  logic signed [wtdr_pkg::COORD_BITS-1:0] cy_i,
  output logic                                   ready_o,
  output wtdr_pkg::pix_t                         pix_o
);
  import wtdr_pkg::*;

  seq_state_e state_q, state_d;

  logic signed [COORD_BITS-1:0] vx_q [3];
  logic signed [COORD_BITS-1:0] vy_q [3];
  logic [EDGE_BITS-1:0]         edge_q;
  logic [DELTA_BITS-1:0]        idx_q;
  logic [DELTA_BITS-1:0]        total_q;
  logic signed [ACC_BITS-1:0]   acc_x_q;
  logic signed [ACC_BITS-1:0]   acc_y_q;
  logic signed [INC_BITS-1:0]   inc_x_q;
  logic signed [INC_BITS-1:0]   inc_y_q;
  logic [DELTA_BITS-1:0]        abs_dy_q;
  logic                         neg_x_q;
  logic                         neg_y_q;

  logic signed [DELTA_BITS-1:0] dx, dy;
  logic [DELTA_BITS-1:0]        abs_dx, abs_dy, len;
  logic                         load, step, edge_end;
  logic signed [INC_BITS-1:0]   quot_s;
  logic signed [ACC_BITS-1:0]   rnd_x, rnd_y;

  div_req_t div_req;
  div_rsp_t div_rsp;

  wtdr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign dx     = DELTA_BITS'(vx_q[1]) - DELTA_BITS'(vx_q[0]);
  assign dy     = DELTA_BITS'(vy_q[1]) - DELTA_BITS'(vy_q[0]);
  assign abs_dx = dx[DELTA_BITS-1] ? -dx : dx;
  assign abs_dy = dy[DELTA_BITS-1] ? -dy : dy;
  assign len    = (abs_dx > abs_dy) ? abs_dx : abs_dy;

  assign load     = take_i && (kind_i == KIND_LOAD);
  assign step     = take_i && (kind_i == KIND_STEP) && (state_q == ST_WALK);
  assign edge_end = idx_q >= total_q;
  assign quot_s   = {1'b0, div_rsp.quot};

  assign rnd_x = acc_x_q + (acc_x_q[ACC_BITS-1] ? ACC_BITS'((1 << (FRAC_BITS - 1)) - 1)
                                                : ACC_BITS'(1 << (FRAC_BITS - 1)));
  assign rnd_y = acc_y_q + (acc_y_q[ACC_BITS-1] ? ACC_BITS'((1 << (FRAC_BITS - 1)) - 1)
                                                : ACC_BITS'(1 << (FRAC_BITS - 1)));

  always_comb begin
    state_d = state_q;
    if (load) begin
      state_d = ST_SETUP;
    end else begin
      case (state_q)
        ST_IDLE:  state_d = ST_IDLE;
        ST_SETUP: state_d = ST_DIV_X;
        ST_DIV_X: if (div_rsp.done) begin
          state_d = ST_DIV_Y;
        end
        ST_DIV_Y: if (div_rsp.done) begin
          state_d = ST_WALK;
        end
        ST_WALK:  if (step && edge_end) begin
          state_d = (edge_q == EDGE_CA) ? ST_IDLE : ST_SETUP;
        end
        default:  state_d = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    ready_o       = (state_q == ST_IDLE) || (state_q == ST_WALK);
    div_req.start = 1'b0;
    div_req.num   = abs_dy_q;
    div_req.den   = total_q;
    case (state_q)
      ST_SETUP: begin
        div_req.start = 1'b1;
        div_req.num   = abs_dx;
        div_req.den   = len;
      end
      ST_DIV_X: div_req.start = div_rsp.done;
      default:  div_req.start = 1'b0;
    endcase
    pix_o.valid   = step;
    pix_o.x       = rnd_x[FRAC_BITS +: COORD_BITS];
    pix_o.y       = rnd_y[FRAC_BITS +: COORD_BITS];
    pix_o.edge_id = edge_q;
    pix_o.last    = (edge_q == EDGE_CA) && edge_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      edge_q  <= EDGE_AB;
      idx_q   <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        edge_q <= EDGE_AB;
      end else if (state_q == ST_SETUP) begin
        idx_q   <= '0;
        total_q <= len;
      end else if (step) begin
        if (edge_end) begin
          edge_q <= edge_q + 1'b1;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      vx_q[0] <= ax_i;
      vy_q[0] <= ay_i;
      vx_q[1] <= bx_i;
      vy_q[1] <= by_coord_i;
      vx_q[2] <= cx_i;
      vy_q[2] <= cy_i;
    end else if (step && edge_end) begin
      vx_q[0] <= vx_q[1];
      vy_q[0] <= vy_q[1];
      vx_q[1] <= vx_q[2];
      vy_q[1] <= vy_q[2];
      vx_q[2] <= vx_q[0];
      vy_q[2] <= vy_q[0];
    end
    if (state_q == ST_SETUP) begin
      acc_x_q  <= ACC_BITS'(vx_q[0]) <<< FRAC_BITS;
      acc_y_q  <= ACC_BITS'(vy_q[0]) <<< FRAC_BITS;
      abs_dy_q <= abs_dy;
      neg_x_q  <= dx[DELTA_BITS-1];
      neg_y_q  <= dy[DELTA_BITS-1];
    end else if (step && !edge_end) begin
      acc_x_q <= acc_x_q + ACC_BITS'(inc_x_q);
      acc_y_q <= acc_y_q + ACC_BITS'(inc_y_q);
    end
    if ((state_q == ST_DIV_X) && div_rsp.done) begin
      inc_x_q <= (total_q == '0) ? '0 : (neg_x_q ? -quot_s : quot_s);
    end
    if ((state_q == ST_DIV_Y) && div_rsp.done) begin
      inc_y_q <= (total_q == '0) ? '0 : (neg_y_q ? -quot_s : quot_s);
    end
  end

endmodule

// File: tb/wtdr_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtdr_pixel_checker
// Watches the command, pixel and color channels of the wireframe triangle
// rasterizer. It keeps its own copy of the vertices, the edge walk and the
// color, works out each pixel word that an accepted step should give, and
// compares every accepted pixel word field by field with the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module wtdr_pixel_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [71:0] s_tdata_i,   // ax, ay, bx, by_coord, cx, cy
  input  logic [0:0]  s_tuser_i,   // kind
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,   // pixel_x, pixel_y, pixel_rgba, edge_id, zero pad
  input  logic        m_tlast_i,
  output int          mismatch_count_o,
  output int          pending_o,
  output logic        tri_busy_o
);
  import wtdr_pkg::*;

  localparam int Y_LO    = COORD_BITS;
  localparam int RGBA_LO = 2 * COORD_BITS;
  localparam int EDGE_LO = RGBA_LO + COLOR_BITS;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] rgba;
    logic [EDGE_BITS-1:0]  edge_id;
    logic                  last;
  } pixel_word_t;

  pixel_word_t           pixel_q[$];
  longint                vert_x[3];
  longint                vert_y[3];
  logic [EDGE_BITS-1:0]  walk_edge = EDGE_AB;
  longint                walk_idx  = 0;
  longint                walk_len  = 0;
  longint                pos_x     = 0;
  longint                pos_y     = 0;
  longint                step_x    = 0;
  longint                step_y    = 0;
  bit                    drawing   = 1'b0;
  logic [COLOR_BITS-1:0] color     = COLOR_RESET;
  int                    mismatches = 0;

  assign mismatch_count_o = mismatches;

  initial pending_o = 0;
  initial tri_busy_o = 1'b0;

  function automatic longint round_pixel(longint v);
    longint half;
    half = longint'(1) << (FRAC_BITS - 1);
    if (v >= 0) return (v + half) >>> FRAC_BITS;
    return -((-v + half) >>> FRAC_BITS);
  endfunction

  function void open_edge(logic [EDGE_BITS-1:0] e);
    int     s;
    int     t;
    longint dx;
    longint dy;
    longint adx;
    longint ady;
    longint one;
    s   = int'(e);
    t   = (s + 1) % 3;
    one = longint'(1) << FRAC_BITS;
    dx  = vert_x[t] - vert_x[s];
    dy  = vert_y[t] - vert_y[s];
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    walk_edge = e;
    walk_idx  = 0;
    walk_len  = (adx > ady) ? adx : ady;
    pos_x     = vert_x[s] * one;
    pos_y     = vert_y[s] * one;
    if (walk_len == 0) begin
      step_x = 0;
      step_y = 0;
    end else begin
      step_x = (dx * one) / walk_len;
      step_y = (dy * one) / walk_len;
    end
  endfunction

  function void take_word(logic kind, logic [71:0] d);
    pixel_word_t p;
    if (kind == KIND_LOAD) begin
      for (int k = 0; k < 3; k++) begin
        vert_x[k] = longint'($signed(d[2*COORD_BITS*k +: COORD_BITS]));
        vert_y[k] = longint'($signed(d[2*COORD_BITS*k + COORD_BITS +: COORD_BITS]));
      end
      open_edge(EDGE_AB);
      drawing = 1'b1;
    end else if (drawing) begin
      p.x       = COORD_BITS'(round_pixel(pos_x));
      p.y       = COORD_BITS'(round_pixel(pos_y));
      p.rgba    = color;
      p.edge_id = walk_edge;
      p.last    = (walk_edge == EDGE_CA) && (walk_idx >= walk_len);
      pixel_q.push_back(p);
      if (walk_idx >= walk_len) begin
        if (walk_edge == EDGE_CA) drawing = 1'b0;
        else open_edge(walk_edge + 2'd1);
      end else begin
        walk_idx++;
        pos_x += step_x;
        pos_y += step_y;
      end
    end
  endfunction

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_word_t want;
    if (!rst_ni) begin
      foreach (vert_x[k]) begin
        vert_x[k] = 0;
        vert_y[k] = 0;
      end
      walk_edge = EDGE_AB;
      walk_idx  = 0;
      walk_len  = 0;
      pos_x     = 0;
      pos_y     = 0;
      step_x    = 0;
      step_y    = 0;
      drawing   = 1'b0;
      color     = COLOR_RESET;
      pixel_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) color = cfg_data_i;
      if (s_tvalid_i && s_tready_i) take_word(s_tuser_i[0], s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("unexpected pixel word", m_tdata_i, '0);
        end else begin
          want = pixel_q.pop_front();
          if (m_tdata_i[0 +: COORD_BITS] !== want.x)
            report_mismatch("pixel_x", m_tdata_i[0 +: COORD_BITS], want.x);
          if (m_tdata_i[Y_LO +: COORD_BITS] !== want.y)
            report_mismatch("pixel_y", m_tdata_i[Y_LO +: COORD_BITS], want.y);
          if (m_tdata_i[RGBA_LO +: COLOR_BITS] !== want.rgba)
            report_mismatch("pixel_rgba", m_tdata_i[RGBA_LO +: COLOR_BITS], want.rgba);
          if (m_tdata_i[EDGE_LO +: EDGE_BITS] !== want.edge_id)
            report_mismatch("edge_id", m_tdata_i[EDGE_LO +: EDGE_BITS], want.edge_id);
          if (m_tlast_i !== want.last)
            report_mismatch("last", m_tlast_i, want.last);
        end
      end
    end
    pending_o  <= pixel_q.size();
    tri_busy_o <= drawing;
  end

endmodule

// File: tb/wireframe_triangle_dda_raster_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wireframe_triangle_dda_raster_core_test
// Drives load and step commands into the rasterizer: a directed set of
// degenerate, half-rounding, replaced and full-range triangles, then
// random phases of mostly small triangles under several pixel colors.
// Both stream sides idle in random bursts except in the final phase; the
// checker beside the block predicts and compares every pixel word.
// ----------------------------------------------------------------------------
module wireframe_triangle_dda_raster_core_test;
  import wtdr_pkg::*;

  localparam int LIMIT      = 3_000_000;
  localparam int SETUP_WAIT = 2 * (FRAC_BITS + 1) + 8;
  localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = KIND_STEP;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;

  int   fail_count;
  int   pending;
  logic tri_busy;
  int   cycles     = 0;
  int   stall_left = 0;
  bit   gaps_on    = 1'b1;
  bit   stall_on   = 1'b1;

  always #2 clk_i = ~clk_i;

  wireframe_triangle_dda_raster_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  wtdr_pixel_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tlast_i        (m_axis_tlast),
    .mismatch_count_o (fail_count),
    .pending_o        (pending),
    .tri_busy_o       (tri_busy)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // pixel side back-pressure in random bursts
  always @(posedge clk_i) begin
    if (stall_on && stall_left == 0 && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 10);
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [71:0] rand_word();
    logic [71:0] w;
    w[31:0]  = $urandom;
    w[63:32] = $urandom;
    w[71:64] = 8'($urandom);
    return w;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic logic [71:0] pack_tri(int x0, int y0, int x1, int y1, int x2, int y2);
    return {12'(y2), 12'(x2), 12'(y1), 12'(x1), 12'(y0), 12'(x0)};
  endfunction

  task automatic send_word(logic kind, logic [71:0] data);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic load_tri(int x0, int y0, int x1, int y1, int x2, int y2);
    send_word(KIND_LOAD, pack_tri(x0, y0, x1, y1, x2, y2));
  endtask

  task automatic send_steps(int n);
    repeat (n) send_word(KIND_STEP, rand_word());
  endtask

  task automatic wait_results();
    while (pending != 0) @(posedge clk_i);
  endtask

  // replace any triangle in progress by a point, step it out, then let the
  // block fall idle
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    if (tri_busy) load_tri(0, 0, 0, 0, 0, 0);
    while (tri_busy) send_word(KIND_STEP, rand_word());
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait_results();
    repeat (SETUP_WAIT) @(posedge clk_i);
  endtask

  task automatic write_color(logic [31:0] c);
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_load();
    int bx0;
    int by0;
    int spread;
    int v[6];
    if ($urandom_range(0, 31) == 0) begin
      send_word(KIND_LOAD, rand_word());
    end else begin
      case ($urandom_range(0, 4))
        0:       spread = 0;
        1:       spread = 1;
        2:       spread = 3;
        3:       spread = 12;
        default: spread = 40;
      endcase
      bx0 = int'($urandom_range(0, 4095)) + COORD_MIN;
      by0 = int'($urandom_range(0, 4095)) + COORD_MIN;
      foreach (v[k])
        v[k] = clamp_coord(((k % 2) ? by0 : bx0) + int'($urandom_range(0, 2 * spread)) - spread);
      load_tri(v[0], v[1], v[2], v[3], v[4], v[5]);
    end
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 || $urandom_range(0, 199) == 0) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        wait_results();
      end
      if ($urandom_range(0, 15) == 0) random_load();
      else send_word(KIND_STEP, rand_word());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_steps(2);
    load_tri(0, 0, 0, 0, 0, 0);
    send_steps(4);
    load_tri(-5, -3, -4, -1, -6, 2);
    send_steps(5);
    load_tri(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_steps(3);
    load_tri(7, 7, 7, 7, 10, 5);
    send_steps(3);
    load_tri(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX);

    write_color(32'h0000_0000);
    run_random(500);
    write_color(32'hFFFF_FFFF);
    run_random(500);
    write_color($urandom);
    run_random(500);
    write_color($urandom);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    run_random(250);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait_results();
    repeat (SETUP_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
